### sv/gtpu_pkg.sv
// package with payload types, parse phases and constants of the gtp-u header parser
package gtpu_pkg;

   // width of the length arithmetic and of the byte position counter
   localparam int LENGTH_BITS = 16;

   // fixed header checks
   localparam logic [3:0] GTP_VERSION_V1  = 4'h3;
   localparam logic [7:0] MSG_TYPE_TPDU   = 8'hff;
   localparam int         MIN_PACKET_LEN  = 12;
   localparam int         MANDATORY_LEN   = 8;
   localparam int         OPTIONAL_END    = 12;
   localparam int         LAST_FIXED_POS  = 7;
   localparam int         LAST_OPT_POS    = 11;
   localparam logic [3:0] IP_VERSION_V6   = 4'h6;

   // result codes
   localparam logic [1:0] VERDICT_NONE = 2'd0;
   localparam logic [1:0] VERDICT_IPV4 = 2'd1;
   localparam logic [1:0] VERDICT_IPV6 = 2'd2;

   typedef enum logic [2:0] {
      PH_FIXED   = 3'd0,
      PH_OPT     = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_EXTSKIP = 3'd3,
      PH_EXTNEXT = 3'd4,
      PH_INNER   = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic [15:0] packet_length;
      logic        is_last;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [15:0] inner_offset;
      logic [15:0] inner_length;
   } rsp_type;

endpackage

### sv/gtpu_header_parser_top.sv
// gtp-u v1 header parser: byte stream in, one verdict per packet out
//
// usage: the udp payload enters on the req_ channel, one byte per beat, with
// the payload length on every beat and is_last on the final byte. the block
// checks the gtp-u v1 fixed header, skips the optional fields, walks the
// extension header chain and, on the last byte, gives one rsp_ beat with the
// verdict (not gtp, inner ipv4, inner ipv6), inner offset and inner length.
// bytes that are not last give no rsp_ beat.
// throughput: one byte per cycle unless stalled; the per-byte state update is
// a single pass of logic between the parser state registers and the result
// register. the result appears in the cycle after the last byte is accepted.
// stall: the result register holds its beat until rsp_ready; while it is
// full and rsp_ready is low, req_ready is low, otherwise bytes keep flowing.
// reset: synchronous, active high; parser returns to the fixed header phase
// at byte position 0 and the result register is emptied. the parser also
// returns to that state after every last byte.
module gtpu_header_parser_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gtpu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gtpu_pkg::rsp_type rsp_data
);

   localparam int LB = gtpu_pkg::LENGTH_BITS;

   // parser state
   logic [LB-1:0]       pos_ff, pos_in;
   gtpu_pkg::phase_type phase_ff, phase_in;
   logic [2:0]          flags_ff, flags_in;
   logic [7:0]          len_hi_ff, len_hi_in;
   logic [9:0]          skip_ff, skip_in;
   logic [LB-1:0]       hdr_end_ff, hdr_end_in;
   logic                is_v6_ff, is_v6_in;
   logic                reject_ff, reject_in;

   // result register
   logic                rsp_valid_ff;
   gtpu_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [7:0]          b;
   logic [LB-1:0]       len;
   logic                accept;
   logic                in_header;

   assign b         = req_data.byte_value;
   assign len       = req_data.packet_length[LB-1:0];
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign in_header = !(phase_ff inside {gtpu_pkg::PH_INNER, gtpu_pkg::PH_DONE});

   // per-byte state update and result
   always_comb begin
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      flags_in    = flags_ff;
      len_hi_in   = len_hi_ff;
      skip_in     = skip_ff;
      hdr_end_in  = hdr_end_ff;
      is_v6_in    = is_v6_ff;
      reject_in   = reject_ff;
      rsp_data_in = '0;

      if (!reject_ff) begin
         if (in_header) begin
            if (pos_ff >= len) begin
               // header byte beyond the payload
               reject_in = 1'b1;
            end else begin
               case (phase_ff)
                  gtpu_pkg::PH_FIXED: begin
                     if (pos_ff == LB'(0)) begin
                        flags_in = b[2:0];
                        if (len <= LB'(gtpu_pkg::MIN_PACKET_LEN) ||
                            b[7:4] != gtpu_pkg::GTP_VERSION_V1) begin
                           reject_in = 1'b1;
                        end
                     end else if (pos_ff == LB'(1)) begin
                        if (b != gtpu_pkg::MSG_TYPE_TPDU) begin
                           reject_in = 1'b1;
                        end
                     end else if (pos_ff == LB'(2)) begin
                        len_hi_in = b;
                     end else if (pos_ff == LB'(3)) begin
                        if (len < LB'(gtpu_pkg::MANDATORY_LEN) ||
                            {len_hi_ff, b} !=
                            16'(len - LB'(gtpu_pkg::MANDATORY_LEN))) begin
                           reject_in = 1'b1;
                        end
                     end else if (pos_ff >= LB'(gtpu_pkg::LAST_FIXED_POS)) begin
                        if (flags_ff != 3'd0) begin
                           phase_in = gtpu_pkg::PH_OPT;
                        end else begin
                           hdr_end_in = LB'(gtpu_pkg::MANDATORY_LEN);
                           phase_in   = gtpu_pkg::PH_INNER;
                        end
                     end
                  end
                  gtpu_pkg::PH_OPT: begin
                     if (pos_ff >= LB'(gtpu_pkg::LAST_OPT_POS)) begin
                        if (b != 8'd0) begin
                           phase_in = gtpu_pkg::PH_EXTLEN;
                        end else begin
                           hdr_end_in = LB'(gtpu_pkg::OPTIONAL_END);
                           phase_in   = gtpu_pkg::PH_INNER;
                        end
                     end
                  end
                  gtpu_pkg::PH_EXTLEN: begin
                     if (b == 8'd0) begin
                        reject_in = 1'b1;
                     end else begin
                        // four-byte units, minus the length and next-type bytes
                        skip_in  = {b, 2'b00} - 10'd2;
                        phase_in = gtpu_pkg::PH_EXTSKIP;
                     end
                  end
                  gtpu_pkg::PH_EXTSKIP: begin
                     skip_in = skip_ff - {9'd0, skip_ff != 10'd0};
                     if (skip_in == 10'd0) begin
                        phase_in = gtpu_pkg::PH_EXTNEXT;
                     end
                  end
                  default: begin
                     // next extension type byte
                     if (b != 8'd0) begin
                        phase_in = gtpu_pkg::PH_EXTLEN;
                     end else begin
                        hdr_end_in = pos_ff + LB'(1);
                        phase_in   = gtpu_pkg::PH_INNER;
                     end
                  end
               endcase
            end
         end else if (phase_ff == gtpu_pkg::PH_INNER && pos_ff == hdr_end_ff &&
                      pos_ff < len) begin
            // first inner byte carries the ip version
            is_v6_in = (b[7:4] == gtpu_pkg::IP_VERSION_V6);
            phase_in = gtpu_pkg::PH_DONE;
         end
      end

      // saturating byte position
      if (pos_ff != {LB{1'b1}}) begin
         pos_in = pos_ff + LB'(1);
      end

      // verdict from the updated state
      if (reject_in || !(phase_in inside {gtpu_pkg::PH_INNER, gtpu_pkg::PH_DONE}) ||
          hdr_end_in > len) begin
         rsp_data_in = '0;
      end else begin
         rsp_data_in.verdict = (phase_in == gtpu_pkg::PH_DONE && is_v6_in) ?
                               gtpu_pkg::VERDICT_IPV6 : gtpu_pkg::VERDICT_IPV4;
         rsp_data_in.inner_offset = 16'(hdr_end_in);
         rsp_data_in.inner_length = 16'(len - hdr_end_in);
      end

      // back to the start of a packet after the last byte
      if (req_data.is_last) begin
         pos_in     = '0;
         phase_in   = gtpu_pkg::PH_FIXED;
         flags_in   = '0;
         len_hi_in  = '0;
         skip_in    = '0;
         hdr_end_in = '0;
         is_v6_in   = 1'b0;
         reject_in  = 1'b0;
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         phase_ff   <= gtpu_pkg::PH_FIXED;
         flags_ff   <= '0;
         len_hi_ff  <= '0;
         skip_ff    <= '0;
         hdr_end_ff <= '0;
         is_v6_ff   <= 1'b0;
         reject_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         flags_ff   <= flags_in;
         len_hi_ff  <= len_hi_in;
         skip_ff    <= skip_in;
         hdr_end_ff <= hdr_end_in;
         is_v6_ff   <= is_v6_in;
         reject_ff  <= reject_in;
      end
   end

   // result register, loaded on the last byte of a packet
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_data.is_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.is_last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### test/tb_gtpu_header_parser_top.sv
// testbench for the gtp-u v1 header parser: byte stream stimulus and verdict scoreboard
`timescale 1ns / 1ps

module tb_gtpu_header_parser_top;
   import gtpu_pkg::*;

   localparam int CYCLE_LIMIT    = 2_000_000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int TAIL_BEATS     = 200;
   localparam int RANDOM_BEATS   = 450;
   localparam int RANDOM_PACKETS = 16;
   localparam int REPORT_LIMIT   = 10;
   localparam int POS_LIMIT      = (1 << LENGTH_BITS) - 1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // byte beats waiting to be driven, verdicts waiting to arrive
   req_type   byte_feed_q[$];
   rsp_type   verdict_q[$];

   // parser state of the predictor
   int        pos_count;
   phase_type phase;
   logic [7:0] flags_byte;
   logic [15:0] len_field;
   int        skip_left;
   int        hdr_end;
   logic [3:0] inner_nibble;
   logic      rejected;

   int   fail_count = 0;
   int   cycle_count = 0;
   int   req_gap_left = 0;
   int   rsp_gap_left = 0;
   logic quiet = 1'b0;
   logic calm = 1'b0;

   gtpu_header_parser_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // return the predictor to the start of a packet
   task automatic clear_parser();
      pos_count    = 0;
      phase        = PH_FIXED;
      flags_byte   = '0;
      len_field    = '0;
      skip_left    = 0;
      hdr_end      = 0;
      inner_nibble = '0;
      rejected     = 1'b0;
   endtask

   // header walk for one byte that is still inside the gtp header
   task automatic walk_header(input logic [7:0] b, input int pos, input int len);
      if (pos >= len) begin
         rejected = 1'b1;
         return;
      end
      case (phase)
         PH_FIXED: begin
            if (pos == 0) begin
               flags_byte = b;
               if (len <= MIN_PACKET_LEN || b[7:4] != GTP_VERSION_V1) rejected = 1'b1;
            end else if (pos == 1) begin
               if (b != MSG_TYPE_TPDU) rejected = 1'b1;
            end else if (pos == 2) begin
               len_field = {b, 8'h00};
            end else if (pos == 3) begin
               len_field[7:0] = b;
               if (len < MANDATORY_LEN || int'(len_field) != len - MANDATORY_LEN)
                  rejected = 1'b1;
            end else if (pos >= LAST_FIXED_POS) begin
               if (flags_byte[2:0] != 3'd0) begin
                  phase = PH_OPT;
               end else begin
                  hdr_end = MANDATORY_LEN;
                  phase   = PH_INNER;
               end
            end
         end
         PH_OPT: begin
            if (pos >= LAST_OPT_POS) begin
               if (b != 8'h00) begin
                  phase = PH_EXTLEN;
               end else begin
                  hdr_end = OPTIONAL_END;
                  phase   = PH_INNER;
               end
            end
         end
         PH_EXTLEN: begin
            if (b == 8'h00) begin
               rejected = 1'b1;
            end else begin
               skip_left = (int'(b) * 4 - 2) & 'h3ff;
               phase     = PH_EXTSKIP;
            end
         end
         PH_EXTSKIP: begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) phase = PH_EXTNEXT;
         end
         default: begin
            if (b != 8'h00) begin
               phase = PH_EXTLEN;
            end else begin
               hdr_end = (pos + 1) & POS_LIMIT;
               phase   = PH_INNER;
            end
         end
      endcase
   endtask

   // predict the effect of one accepted byte beat
   task automatic parse_byte(input req_type beat);
      int      len;
      int      pos;
      rsp_type res;
      len = int'(beat.packet_length) & POS_LIMIT;
      pos = pos_count;
      if (!rejected) begin
         if (phase <= PH_EXTNEXT) begin
            walk_header(beat.byte_value, pos, len);
         end else if (phase == PH_INNER && pos == hdr_end && pos < len) begin
            inner_nibble = beat.byte_value[7:4];
            phase        = PH_DONE;
         end
      end
      if (pos_count < POS_LIMIT) pos_count++;
      if (beat.is_last) begin
         if (rejected || phase <= PH_EXTNEXT || hdr_end > len) begin
            res = '{VERDICT_NONE, 16'd0, 16'd0};
         end else begin
            res.verdict = (phase == PH_DONE && inner_nibble == IP_VERSION_V6) ?
                          VERDICT_IPV6 : VERDICT_IPV4;
            res.inner_offset = 16'(hdr_end);
            res.inner_length = 16'(len - hdr_end);
         end
         verdict_q.push_back(res);
         clear_parser();
      end
   endtask

   // build one gtp-u packet, patch its length field and queue its bytes
   task automatic queue_gtp(input logic [7:0] flags, input logic [7:0] msg, input int n_ext,
                            input int ext_units, input int inner_bytes,
                            input logic [3:0] ip_nib, input int len_adj, input int lf_adj,
                            input int cut);
      logic [7:0]  s[$];
      logic [15:0] lf;
      int          len;
      s.push_back(flags);
      s.push_back(msg);
      s.push_back(8'h00);
      s.push_back(8'h00);
      repeat (4) s.push_back(8'($urandom));
      if (flags[2:0] != 3'd0) begin
         repeat (3) s.push_back(8'($urandom));
         s.push_back(n_ext > 0 ? 8'($urandom_range(1, 255)) : 8'h00);
         for (int i = 0; i < n_ext; i++) begin
            s.push_back(8'(ext_units));
            repeat (4 * ext_units - 2) s.push_back(8'($urandom));
            s.push_back(i < n_ext - 1 ? 8'($urandom_range(1, 255)) : 8'h00);
         end
      end
      for (int i = 0; i < inner_bytes; i++)
         s.push_back(i == 0 ? {ip_nib, 4'($urandom)} : 8'($urandom));
      len = s.size() + len_adj;
      if (len < 0) len = 0;
      if (len > POS_LIMIT) len = POS_LIMIT;
      lf   = 16'(len - MANDATORY_LEN + lf_adj);
      s[2] = lf[15:8];
      s[3] = lf[7:0];
      for (int i = 0; i < cut && s.size() > 1; i++) void'(s.pop_back());
      foreach (s[i]) byte_feed_q.push_back('{s[i], 16'(len), i == s.size() - 1});
   endtask

   // random bytes with an arbitrary length
   task automatic queue_noise(input int n, input int len);
      for (int i = 0; i < n; i++)
         byte_feed_q.push_back('{8'($urandom), 16'(len), i == n - 1});
   endtask

   // random packets, mostly well formed with one field broken now and then
   task automatic queue_random();
      int         start;
      int         packets;
      int         pick;
      logic [7:0] flags;
      logic [7:0] msg;
      logic [3:0] nib;
      int         n_ext, units, inner, len_adj, lf_adj, cut;
      start   = byte_feed_q.size();
      packets = 0;
      while (byte_feed_q.size() - start < RANDOM_BEATS || packets < RANDOM_PACKETS) begin
         packets++;
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            queue_noise($urandom_range(1, 20),
                        $urandom_range(0, 1) ? $urandom_range(0, 40) : int'(16'($urandom)));
            continue;
         end
         flags   = {GTP_VERSION_V1, 4'($urandom)};
         msg     = MSG_TYPE_TPDU;
         n_ext   = flags[2:0] != 3'd0 ? $urandom_range(0, 3) : 0;
         units   = $urandom_range(1, 3);
         inner   = $urandom_range(0, 24);
         len_adj = 0;
         lf_adj  = 0;
         cut     = 0;
         case ($urandom_range(0, 3))
            0, 1:    nib = 4'h4;
            2:       nib = IP_VERSION_V6;
            default: nib = 4'($urandom);
         endcase
         if (pick <= 2) begin
            case ($urandom_range(0, 5))
               0:       msg = 8'($urandom);
               1:       flags = 8'($urandom);
               2:       lf_adj = $urandom_range(0, 1) ? $urandom_range(1, 3) : -1;
               3:       cut = $urandom_range(1, 15);
               4:       len_adj = $urandom_range(0, 20) - 10;
               default: begin
                  flags[2] = 1'b1;
                  n_ext    = 1;
                  units    = 0;
               end
            endcase
         end
         queue_gtp(flags, msg, n_ext, units, inner, nib, len_adj, lf_adj, cut);
      end
   endtask

   // byte driver: presents queued beats, holds each until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_valid && req_ready) parse_byte(req_data);
         if (!req_valid || req_ready) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_valid <= 1'b0;
            end else if (byte_feed_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
               req_gap_left = $urandom_range(0, 3);
               req_valid    <= 1'b0;
            end else begin
               req_data  <= byte_feed_q.pop_front();
               req_valid <= 1'b1;
            end
         end
         quiet <= byte_feed_q.size() < TAIL_BEATS;
         if ($urandom_range(0, 99) == 0) calm <= !calm;
      end
   end

   // verdict monitor: checks each result beat and stalls the result side
   always @(posedge clock) begin : verdict_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready    <= 1'b0;
         rsp_gap_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected result beat: verdict %0d offset %0d length %0d",
                           rsp_data.verdict, rsp_data.inner_offset, rsp_data.inner_length);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.verdict !== want.verdict ||
                   rsp_data.inner_offset !== want.inner_offset ||
                   rsp_data.inner_length !== want.inner_length) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("result mismatch: verdict %0d/%0d offset %0d/%0d length %0d/%0d",
                              want.verdict, rsp_data.verdict, want.inner_offset,
                              rsp_data.inner_offset, want.inner_length, rsp_data.inner_length);
               end
            end
         end
         if (rsp_gap_left > 0) begin
            rsp_gap_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
            rsp_gap_left = $urandom_range(0, 3);
            rsp_ready    <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      clear_parser();
      // valid headers without options, inner ipv4 and ipv6
      queue_gtp({GTP_VERSION_V1, 4'h0}, MSG_TYPE_TPDU, 0, 1, 6, 4'h4, 0, 0, 0);
      queue_gtp({GTP_VERSION_V1, 4'h0}, MSG_TYPE_TPDU, 0, 1, 6, IP_VERSION_V6, 0, 0, 0);
      // optional fields with no extension
      queue_gtp({GTP_VERSION_V1, 4'h2}, MSG_TYPE_TPDU, 0, 1, 5, IP_VERSION_V6, 0, 0, 0);
      // extension chains, one of them long
      queue_gtp({GTP_VERSION_V1, 4'h4}, MSG_TYPE_TPDU, 1, 1, 4, 4'h4, 0, 0, 0);
      queue_gtp({GTP_VERSION_V1, 4'h7}, MSG_TYPE_TPDU, 2, 2, 4, IP_VERSION_V6, 0, 0, 0);
      queue_gtp({GTP_VERSION_V1, 4'hc}, MSG_TYPE_TPDU, 1, 40, 2, 4'h4, 0, 0, 0);
      // zero extension length
      queue_gtp({GTP_VERSION_V1, 4'h4}, MSG_TYPE_TPDU, 1, 0, 4, 4'h4, 0, 0, 0);
      // bad version, message type and length field
      queue_gtp(8'h20, MSG_TYPE_TPDU, 0, 1, 6, 4'h4, 0, 0, 0);
      queue_gtp({GTP_VERSION_V1, 4'h0}, 8'hfe, 0, 1, 6, 4'h4, 0, 0, 0);
      queue_gtp({GTP_VERSION_V1, 4'h0}, MSG_TYPE_TPDU, 0, 1, 6, 4'h4, 0, 1, 0);
      // packet not longer than the minimum
      queue_gtp({GTP_VERSION_V1, 4'h0}, MSG_TYPE_TPDU, 0, 1, 4, 4'h4, 0, 0, 0);
      // header byte past the length
      queue_gtp({GTP_VERSION_V1, 4'h4}, MSG_TYPE_TPDU, 1, 2, 0, 4'h4, -5, 0, 0);
      // stream ends inside the header
      queue_gtp({GTP_VERSION_V1, 4'h4}, MSG_TYPE_TPDU, 1, 1, 4, 4'h4, 0, 0, 10);
      // header ends exactly at the length
      queue_gtp({GTP_VERSION_V1, 4'h4}, MSG_TYPE_TPDU, 1, 1, 0, 4'h4, 0, 0, 0);
      // stream ends before the inner byte
      queue_gtp({GTP_VERSION_V1, 4'h4}, MSG_TYPE_TPDU, 1, 1, 5, IP_VERSION_V6, 0, 0, 5);
      // extra bytes past the length, in the second packet the inner byte among them
      queue_gtp({GTP_VERSION_V1, 4'h0}, MSG_TYPE_TPDU, 0, 1, 9, IP_VERSION_V6, -3, 0, 0);
      queue_gtp({GTP_VERSION_V1, 4'h4}, MSG_TYPE_TPDU, 1, 1, 3, IP_VERSION_V6, -3, 0, 0);
      // single byte with zero length, then three bytes with the largest length
      queue_noise(1, 0);
      queue_noise(3, 16'hffff);
      queue_random();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (byte_feed_q.size() != 0 || req_valid) @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && verdict_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
